/* hdl/fpa_pkg.sv */
// fpa_pkg: action codes, status codes and the per-word control record
// shared by the front end, the divide/sqrt cells and the top level
`default_nettype none
package fpa_pkg;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_SQRT = 4'd4;
  localparam logic [3:0] OP_ABS  = 4'd5;
  localparam logic [3:0] OP_LT   = 4'd6;
  localparam logic [3:0] OP_LE   = 4'd7;
  localparam logic [3:0] OP_GT   = 4'd8;
  localparam logic [3:0] OP_GE   = 4'd9;
  localparam logic [3:0] OP_EQ   = 4'd10;
  localparam logic [3:0] OP_NE   = 4'd11;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIV0    = 2'd1;
  localparam logic [1:0] ST_NEGSQRT = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic       vld;
    logic [3:0] op;
    logic       neg;
    logic       div0;
    logic       sneg;
    logic [1:0] st;
  } fpa_ctl_t;

endpackage
`default_nettype wire

/* hdl/fixed_point_alu_with_div_sqrt.sv */
// fixed_point_alu_with_div_sqrt: top level, front end, chain of
// divide/sqrt cells and output register; uses fpa_pkg, fpa_front, fpa_cell
`default_nettype none
// Signed fixed-point ALU with FRAC_BITS fraction bits.
// Input channel: action_i, operand_a_i, operand_b_i are taken at a rising
// edge with start_i high and busy_o low. busy_o stays low: a new word may
// be issued in every cycle, and words never wait on one another.
// Output channel: value_o and status_o hold a result for exactly one
// cycle, flagged by done_o; results leave in issue order.
// Every action takes the same path from the accepting edge to done_o:
// the front-end registers, the chain of 64 + FRAC_BITS divider cells,
// one quotient bit per cell, and the output register. The square root
// uses the first half of those cells, two radicand bits each, and the
// multiplier is pipelined in the front end, in front of the chain.
// Throughput: one word per cycle.
// Reset clears all valid flags in flight; no word issued before reset
// appears afterwards. The receiver cannot stall, so nothing is held back.
module fixed_point_alu_with_div_sqrt #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  action_i,
  input  wire logic signed [63:0] operand_a_i,
  input  wire logic signed [63:0] operand_b_i,
  output logic             done_o,
  output logic signed [63:0] value_o,
  output logic [1:0]       status_o
);
  import fpa_pkg::*;

  localparam int DW = 64 + FRAC_BITS;
  localparam int SW = DW + (DW % 2);
  localparam int SQ = SW / 2;
  localparam logic [63:0] EPS = (64'd1 << FRAC_BITS) / 64'd1000000000;

  fpa_ctl_t      ctl_w  [DW+1];
  logic [63:0]   val_w  [DW+1];
  logic [DW-1:0] num_w  [DW+1];
  logic [DW-1:0] quo_w  [DW+1];
  logic [63:0]   rem_w  [DW+1];
  logic [63:0]   den_w  [DW+1];
  logic [SW-1:0] rad_w  [DW+1];
  logic [SQ-1:0] root_w [DW+1];
  logic [SQ:0]   srem_w [DW+1];
  logic [63:0]   mag_a, mag_b;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .EPS(EPS)) u_front (
    .clk_i, .rst_ni, .start_i, .action_i,
    .operand_a_i(operand_a_i), .operand_b_i(operand_b_i),
    .ctl_o(ctl_w[0]), .val_o(val_w[0]), .mag_a_o(mag_a), .mag_b_o(mag_b)
  );

  assign num_w[0]  = DW'({mag_a, {FRAC_BITS{1'b0}}});
  assign quo_w[0]  = '0;
  assign rem_w[0]  = '0;
  assign den_w[0]  = mag_b;
  assign rad_w[0]  = SW'({mag_a, {FRAC_BITS{1'b0}}});
  assign root_w[0] = '0;
  assign srem_w[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpa_cell #(.DW(DW), .SW(SW), .SQ(SQ), .SQRT_EN(i < SQ)) u_cell (
      .clk_i, .rst_ni,
      .ctl_i(ctl_w[i]), .val_i(val_w[i]), .num_i(num_w[i]), .quo_i(quo_w[i]),
      .rem_i(rem_w[i]), .den_i(den_w[i]), .rad_i(rad_w[i]), .root_i(root_w[i]),
      .srem_i(srem_w[i]),
      .ctl_o(ctl_w[i+1]), .val_o(val_w[i+1]), .num_o(num_w[i+1]),
      .quo_o(quo_w[i+1]), .rem_o(rem_w[i+1]), .den_o(den_w[i+1]),
      .rad_o(rad_w[i+1]), .root_o(root_w[i+1]), .srem_o(srem_w[i+1])
    );
  end

  fpa_ctl_t    lc;
  logic [DW-1:0] lq;
  logic [63:0] val_d, val_q;
  logic [1:0]  st_d, st_q;
  logic        done_q;

  always_comb begin
    lc    = ctl_w[DW];
    lq    = quo_w[DW];
    val_d = val_w[DW];
    st_d  = lc.st;
    case (lc.op)
      OP_DIV: begin
        if (lc.div0) begin
          val_d = 64'd0;
          st_d  = ST_DIV0;
        end else if (!lc.neg) begin
          if ((lq[DW-1:64] != '0) || (lq[63:0] > MAX_POS)) begin
            val_d = MAX_POS;
            st_d  = ST_SAT;
          end else begin
            val_d = lq[63:0];
            st_d  = ST_OK;
          end
        end else begin
          if ((lq[DW-1:64] != '0) || (lq[63:0] > MIN_NEG)) begin
            val_d = MIN_NEG;
            st_d  = ST_SAT;
          end else begin
            val_d = 64'd0 - lq[63:0];
            st_d  = ST_OK;
          end
        end
      end
      OP_SQRT: begin
        if (lc.sneg) begin
          val_d = 64'd0;
          st_d  = ST_NEGSQRT;
        end else begin
          val_d = 64'(root_w[DW]);
          st_d  = ST_OK;
        end
      end
      default: begin
        val_d = val_w[DW];
        st_d  = lc.st;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lc.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    st_q  <= st_d;
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign value_o  = val_q;
  assign status_o = st_q;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(DW+6) done_o)
    else $error("result missing at fixed latency");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start_i, DW+6) |-> !done_o)
    else $error("result without issued word");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_DIV0 || status_o == ST_NEGSQRT)) |-> (value_o == 64'd0))
    else $error("error result not zero");
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_SAT) |-> (value_o == MAX_POS || value_o == MIN_NEG))
    else $error("saturated result not at a limit");
`endif

endmodule
`default_nettype wire

/* hdl/fpa_front.sv */
// fpa_front: input register, magnitudes, add/sub/abs/compare results and
// the pipelined 64x64 multiply; uses fpa_pkg
`default_nettype none
module fpa_front #(
  parameter int FRAC_BITS = 32,
  parameter logic [63:0] EPS = 64'd4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [3:0]        action_i,
  input  wire logic [63:0]       operand_a_i,
  input  wire logic [63:0]       operand_b_i,
  output fpa_pkg::fpa_ctl_t      ctl_o,
  output logic [63:0]            val_o,
  output logic [63:0]            mag_a_o,
  output logic [63:0]            mag_b_o
);
  import fpa_pkg::*;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  logic        vld1_q;
  logic [3:0]  op1_q;
  logic [63:0] a1_q, b1_q;

  fpa_ctl_t    ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  fpa_ctl_t    ctl2_d, ctl5_d;
  logic [63:0] val2_d, val2_q, val3_q, val4_q, val5_q;
  logic [63:0] ma2_d, mb2_d, ma2_q, mb2_q, ma3_q, mb3_q, ma4_q, mb4_q, ma5_q, mb5_q;
  logic [63:0] pll_q, plh_q, phl_q, phh_q;
  logic [127:0] prod_q;
  logic [127:0] prod_d;
  logic [63:0]  s_add, s_sub, dif;
  logic         lt, gt, near;
  logic [63:0]  mul_val;
  logic [1:0]   mul_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else begin
      vld1_q <= start_i;
      ctl2_q <= ctl2_d;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl5_d;
    end
  end

  always_comb begin
    ctl5_d = ctl4_q;
    if (ctl4_q.op == OP_MUL) begin
      ctl5_d.st = mul_st;
    end
  end

  always_comb begin
    ma2_d = a1_q[63] ? (64'd0 - a1_q) : a1_q;
    mb2_d = b1_q[63] ? (64'd0 - b1_q) : b1_q;
    s_add = a1_q + b1_q;
    s_sub = a1_q - b1_q;
    lt    = $signed(a1_q) < $signed(b1_q);
    gt    = $signed(b1_q) < $signed(a1_q);
    dif   = lt ? (b1_q - a1_q) : (a1_q - b1_q);
    near  = dif <= EPS;
    ctl2_d.vld  = vld1_q;
    ctl2_d.op   = op1_q;
    ctl2_d.neg  = a1_q[63] ^ b1_q[63];
    ctl2_d.div0 = mb2_d <= EPS;
    ctl2_d.sneg = a1_q[63];
    ctl2_d.st   = ST_OK;
    val2_d      = 64'd0;
    case (op1_q)
      OP_ADD: begin
        if ((a1_q[63] ~^ b1_q[63]) && (a1_q[63] ^ s_add[63])) begin
          val2_d = a1_q[63] ? MIN_NEG : MAX_POS;
          ctl2_d.st = ST_SAT;
        end else begin
          val2_d = s_add;
        end
      end
      OP_SUB: begin
        if ((a1_q[63] ^ b1_q[63]) && (a1_q[63] ^ s_sub[63])) begin
          val2_d = a1_q[63] ? MIN_NEG : MAX_POS;
          ctl2_d.st = ST_SAT;
        end else begin
          val2_d = s_sub;
        end
      end
      OP_ABS: begin
        if (a1_q == MIN_NEG) begin
          val2_d = MAX_POS;
          ctl2_d.st = ST_SAT;
        end else begin
          val2_d = ma2_d;
        end
      end
      OP_LT: val2_d = lt ? ONE : 64'd0;
      OP_LE: val2_d = !gt ? ONE : 64'd0;
      OP_GT: val2_d = gt ? ONE : 64'd0;
      OP_GE: val2_d = !lt ? ONE : 64'd0;
      OP_EQ: val2_d = near ? ONE : 64'd0;
      OP_NE: val2_d = near ? 64'd0 : ONE;
      default: val2_d = 64'd0;
    endcase
  end

  always_comb begin
    prod_d = {64'd0, pll_q} + ({64'd0, plh_q} << 32) + ({64'd0, phl_q} << 32)
           + {phh_q, 64'd0};
  end

  always_comb begin
    mul_st  = ST_OK;
    mul_val = prod_q[FRAC_BITS+63:FRAC_BITS];
    if (!ctl4_q.neg) begin
      if ((prod_q[127:FRAC_BITS+64] != '0) || (mul_val > MAX_POS)) begin
        mul_val = MAX_POS;
        mul_st  = ST_SAT;
      end
    end else begin
      if ((prod_q[127:FRAC_BITS+64] != '0) || (mul_val > MIN_NEG)) begin
        mul_val = MIN_NEG;
        mul_st  = ST_SAT;
      end else begin
        mul_val = 64'd0 - mul_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= action_i;
    a1_q   <= operand_a_i;
    b1_q   <= operand_b_i;
    val2_q <= val2_d;
    ma2_q  <= ma2_d;
    mb2_q  <= mb2_d;
    pll_q  <= 64'(ma2_q[31:0]) * 64'(mb2_q[31:0]);
    plh_q  <= 64'(ma2_q[31:0]) * 64'(mb2_q[63:32]);
    phl_q  <= 64'(ma2_q[63:32]) * 64'(mb2_q[31:0]);
    phh_q  <= 64'(ma2_q[63:32]) * 64'(mb2_q[63:32]);
    val3_q <= val2_q;
    ma3_q  <= ma2_q;
    mb3_q  <= mb2_q;
    prod_q <= prod_d;
    val4_q <= val3_q;
    ma4_q  <= ma3_q;
    mb4_q  <= mb3_q;
    val5_q <= (ctl4_q.op == OP_MUL) ? mul_val : val4_q;
    ma5_q  <= ma4_q;
    mb5_q  <= mb4_q;
  end

  assign ctl_o   = ctl5_q;
  assign val_o   = val5_q;
  assign mag_a_o = ma5_q;
  assign mag_b_o = mb5_q;

endmodule
`default_nettype wire

/* hdl/fpa_cell.sv */
// fpa_cell: one restoring divide step and, with SQRT_EN set, one square root
// digit step, handing the word to the next cell every cycle; uses fpa_pkg
`default_nettype none
module fpa_cell #(
  parameter int DW = 96,
  parameter int SW = 96,
  parameter int SQ = 48,
  parameter bit SQRT_EN = 1'b1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fpa_pkg::fpa_ctl_t ctl_i,
  input  wire logic [63:0]       val_i,
  input  wire logic [DW-1:0]     num_i,
  input  wire logic [DW-1:0]     quo_i,
  input  wire logic [63:0]       rem_i,
  input  wire logic [63:0]       den_i,
  input  wire logic [SW-1:0]     rad_i,
  input  wire logic [SQ-1:0]     root_i,
  input  wire logic [SQ:0]       srem_i,
  output fpa_pkg::fpa_ctl_t      ctl_o,
  output logic [63:0]            val_o,
  output logic [DW-1:0]          num_o,
  output logic [DW-1:0]          quo_o,
  output logic [63:0]            rem_o,
  output logic [63:0]            den_o,
  output logic [SW-1:0]          rad_o,
  output logic [SQ-1:0]          root_o,
  output logic [SQ:0]            srem_o
);
  import fpa_pkg::*;

  fpa_ctl_t      ctl_q;
  logic [63:0]   val_q, rem_q, den_q, rem_d;
  logic [DW-1:0] num_q, quo_q;
  logic [SW-1:0] rad_q, rad_d;
  logic [SQ-1:0] root_q, root_d;
  logic [SQ:0]   srem_q, srem_d;
  logic [64:0]   rem2, rdif;
  logic          ge, sge;
  logic [SQ+2:0] stmp, trial, sdif;

  always_comb begin
    rem2  = {rem_i, num_i[DW-1]};
    rdif  = rem2 - {1'b0, den_i};
    ge    = rem2 >= {1'b0, den_i};
    rem_d = ge ? rdif[63:0] : rem2[63:0];
    stmp  = {srem_i, rad_i[SW-1:SW-2]};
    trial = {1'b0, root_i, 2'b01};
    sdif  = stmp - trial;
    sge   = stmp >= trial;
    if (SQRT_EN) begin
      srem_d = sge ? sdif[SQ:0] : stmp[SQ:0];
      root_d = {root_i[SQ-2:0], sge};
      rad_d  = {rad_i[SW-3:0], 2'b00};
    end else begin
      srem_d = srem_i;
      root_d = root_i;
      rad_d  = rad_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_i;
    num_q  <= {num_i[DW-2:0], 1'b0};
    quo_q  <= {quo_i[DW-2:0], ge};
    rem_q  <= rem_d;
    den_q  <= den_i;
    rad_q  <= rad_d;
    root_q <= root_d;
    srem_q <= srem_d;
  end

  assign ctl_o  = ctl_q;
  assign val_o  = val_q;
  assign num_o  = num_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign rad_o  = rad_q;
  assign root_o = root_q;
  assign srem_o = srem_q;

endmodule
`default_nettype wire

/* tb/fpa_checker.sv */
// fpa_checker: watches the command and result ports of the fixed-point alu,
// predicts each result bit-exact and compares in order; depends on fpa_pkg
`timescale 1ns / 1ps
module fpa_checker #(
  parameter int FRAC_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic [3:0]         action_i,
  input  wire logic signed [63:0] operand_a_i,
  input  wire logic signed [63:0] operand_b_i,
  input  wire logic               done_i,
  input  wire logic signed [63:0] value_i,
  input  wire logic [1:0]         status_i,
  output int                      fail_cnt_o,
  output int                      pending_o
);
  import fpa_pkg::*;

  localparam logic [63:0] EPS_LSB = (64'd1 << FRAC_BITS) / 64'd1000000000;
  localparam logic [63:0] ONE_FX  = 64'd1 << FRAC_BITS;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } alu_word_t;

  alu_word_t expected_q[$];

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic alu_word_t saturate(logic neg, logic [127:0] m);
    alu_word_t r;
    r.status = ST_OK;
    if (!neg) begin
      if (m > {64'd0, MAX_POS}) begin
        r.value = MAX_POS;
        r.status = ST_SAT;
      end else r.value = m[63:0];
    end else begin
      if (m > {64'd0, MIN_NEG}) begin
        r.value = MIN_NEG;
        r.status = ST_SAT;
      end else r.value = 64'd0 - m[63:0];
    end
    return r;
  endfunction

  function automatic alu_word_t predict_alu(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    alu_word_t r;
    logic [63:0] s;
    logic [127:0] w, n, c2;
    logic [63:0] d, root, cand;
    logic signed [63:0] sa, sb;
    sa = a;
    sb = b;
    r.value = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63])) begin
          r.value = a[63] ? MIN_NEG : MAX_POS;
          r.status = ST_SAT;
        end else r.value = s;
      end
      OP_SUB: begin
        s = a - b;
        if ((a[63] != b[63]) && (s[63] != a[63])) begin
          r.value = a[63] ? MIN_NEG : MAX_POS;
          r.status = ST_SAT;
        end else r.value = s;
      end
      OP_MUL: begin
        w = {64'd0, mag(a)} * {64'd0, mag(b)};
        r = saturate(a[63] ^ b[63], w >> FRAC_BITS);
      end
      OP_DIV: begin
        d = mag(b);
        if (d <= EPS_LSB) r.status = ST_DIV0;
        else begin
          n = {64'd0, mag(a)} << FRAC_BITS;
          r = saturate(a[63] ^ b[63], n / {64'd0, d});
        end
      end
      OP_SQRT: begin
        if (a[63]) r.status = ST_NEGSQRT;
        else begin
          n = {64'd0, a} << FRAC_BITS;
          root = '0;
          for (int i = 62; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            c2 = {64'd0, cand} * {64'd0, cand};
            if (c2 <= n) root = cand;
          end
          r.value = root;
        end
      end
      OP_ABS: begin
        if (a == MIN_NEG) begin
          r.value = MAX_POS;
          r.status = ST_SAT;
        end else r.value = mag(a);
      end
      OP_LT: r.value = (sa < sb) ? ONE_FX : '0;
      OP_LE: r.value = (sa <= sb) ? ONE_FX : '0;
      OP_GT: r.value = (sa > sb) ? ONE_FX : '0;
      OP_GE: r.value = (sa >= sb) ? ONE_FX : '0;
      OP_EQ, OP_NE: begin
        s = (sa >= sb) ? (a - b) : (b - a);
        r.value = ((s <= EPS_LSB) ^ (op == OP_NE)) ? ONE_FX : '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    alu_word_t exp_w;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_q.size() == 0) report_mismatch("result word with nothing expected");
        else begin
          exp_w = expected_q.pop_front();
          if (value_i !== exp_w.value)
            report_mismatch($sformatf("value got %h exp %h", value_i, exp_w.value));
          if (status_i !== exp_w.status)
            report_mismatch($sformatf("status got %0d exp %0d", status_i, exp_w.status));
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_alu(action_i, operand_a_i, operand_b_i));
    end
  end
endmodule

/* tb/tb_top.sv */
// tb_top: drives directed and random words into fixed_point_alu_with_div_sqrt
// and gives the verdict; depends on fpa_pkg and fpa_checker
`timescale 1ns / 1ps
module tb_top;
  import fpa_pkg::*;

  localparam int FRAC_BITS = 32;
  localparam int LATENCY = 64 + FRAC_BITS + 6;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [3:0] action_i = OP_ADD;
  logic signed [63:0] operand_a_i = '0;
  logic signed [63:0] operand_b_i = '0;
  logic busy_o, done_o;
  logic signed [63:0] value_o;
  logic [1:0] status_o;
  int fail_cnt, pending, cycle_cnt;
  int idle_pct;

  always #5 clk_i = ~clk_i;

  fixed_point_alu_with_div_sqrt #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .operand_a_i, .operand_b_i,
    .done_o, .value_o, .status_o
  );

  fpa_checker #(.FRAC_BITS(FRAC_BITS)) chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .action_i, .operand_a_i,
    .operand_b_i, .done_i(done_o), .value_i(value_o), .status_i(status_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MAX_POS - $urandom_range(0, 3);
      1: v = MIN_NEG + $urandom_range(0, 3);
      2: v = $signed(64'($urandom_range(0, 10))) - 5;
      3: v = $signed({{32{v[63]}}, v[31:0]});
      4: v = $signed({{16{v[63]}}, v[47:0]});
      default: ;
    endcase
    return v;
  endfunction

  // one word, held until accepted; random gaps before it
  task automatic send_word(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_random(int count);
    logic [63:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = rand_operand();
      b = rand_operand();
      if ($urandom_range(0, 4) == 0) b = a + $signed(64'($urandom_range(0, 12))) - 6;
      send_word(4'($urandom_range(0, 15)), a, b);
    end
  endtask

  initial begin
    logic [63:0] edge_a[6];
    int wait_cnt;
    cycle_cnt = 0;
    idle_pct = 0;
    edge_a = '{MAX_POS, MIN_NEG, 64'd0, 64'd1 << FRAC_BITS, 64'hffff_ffff_ffff_ffff, 64'd4};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int op = 0; op < 16; op++) send_word(4'(op), edge_a[op % 6], edge_a[(op + 1) % 6]);
    send_word(OP_DIV, 64'd1 << FRAC_BITS, 64'd4);
    send_word(OP_DIV, 64'd1 << FRAC_BITS, 64'hffff_ffff_ffff_fffb);
    send_word(OP_SQRT, MIN_NEG, '0);
    send_word(OP_EQ, 64'd100, 64'd104);
    send_word(OP_NE, 64'd100, 64'd105);
    send_word(OP_ABS, MIN_NEG, '0);
    send_word(OP_MUL, MAX_POS, MIN_NEG);
    idle_pct = 38;
    send_random(300);
    idle_pct = 85;
    send_random(300);
    idle_pct = 0;
    send_random(300);
    start_i <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 10 * LATENCY) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
